### rtl/max_mean_sliding_window_unit_defines.svh
// Assertion macros shared by the max-mean sliding window block.
`ifndef MAX_MEAN_SLIDING_WINDOW_UNIT_DEFINES_SVH
`define MAX_MEAN_SLIDING_WINDOW_UNIT_DEFINES_SVH

// Same-cycle implication, clocked by clk and disabled during reset.
`define MMSW_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked by clk and disabled during reset.
`define MMSW_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mmsw_pkg.sv
// Types and constants of the max-mean sliding window block.
`default_nettype none

package mmsw_pkg;

  localparam int unsigned       WINDOW_MAX = 256;
  localparam longint unsigned   LEN_MAX    = 65536;
  localparam int unsigned       VALUE_W    = 32;

  localparam int unsigned AW      = $clog2(WINDOW_MAX);
  localparam int unsigned K_W     = 9;
  localparam int unsigned CNT_W   = $clog2(LEN_MAX + 1);
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned MEAN_W  = 48;
  localparam int unsigned FRAC    = 16;
  localparam int unsigned DVD_W   = SUM_W + FRAC;
  localparam int unsigned DCNT_W  = $clog2(DVD_W);

  // -1.0 in signed Q.16
  localparam logic [MEAN_W-1:0] MEAN_NONE = ~MEAN_W'((1 << FRAC) - 1);

  typedef struct packed {
    logic                    found;
    logic                    overflow;
    logic signed [SUM_W-1:0] best_sum;
    logic [IDX_W-1:0]        start_index;
    logic [IDX_W-1:0]        end_index;
    logic [K_W-1:0]          k;
  } res_t;

endpackage

`default_nettype wire

### rtl/mmsw_if.sv
// Stream interfaces of the max-mean sliding window block.
`default_nettype none

interface mmsw_in_if;
  import mmsw_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface mmsw_out_if;
  import mmsw_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     found;
  logic                     overflow;
  logic signed [SUM_W-1:0]  best_sum;
  logic signed [MEAN_W-1:0] mean_q16;
  logic [IDX_W-1:0]         start_index;
  logic [IDX_W-1:0]         end_index;

  modport source (output valid, output found, output overflow, output best_sum,
                  output mean_q16, output start_index, output end_index, input ready);
  modport sink   (input valid, input found, input overflow, input best_sum,
                  input mean_q16, input start_index, input end_index, output ready);
endinterface

`default_nettype wire

### rtl/max_mean_sliding_window_unit.sv
// Top level of the max-mean sliding window block.
// Usage:
//   in_ch takes one signed word per cycle while ready; last marks the end of a stream.
//   cfg_wr_en/cfg_wr_data set the window length k (0 acts as 1, above 256 as 256);
//   write it only while no stream is in flight. Reset value is 1.
//   out_ch gives one result word per stream: found, overflow, best sum, mean in
//   signed Q.16 (truncated toward zero) and start/end index of the best window.
// Throughput: one word per cycle inside a stream while in_ch.ready is high; the window
//   store is read and written once per word, the running sum updated in the cycle after.
// Result path: the last word's sums are formed in stage B, which starts the divider;
//   when a window was found the bit-serial divider works through the 56-bit dividend,
//   else it goes straight to its done state; out_ch.valid rises once the result is
//   loaded into the output register. in_ch holds ready low from the last word until
//   the divider is free again.
// Reset: clears stream state and the output valid flag; k returns to 1. The window
//   store is not cleared, its entries are written before they are read.
// Stall: a result waiting on out_ch does not block the next stream; a second
//   result waits in the divider, holding in_ch off, until out_ch takes the first.
`default_nettype none
`include "max_mean_sliding_window_unit_defines.svh"

module max_mean_sliding_window_unit (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr_en,
  input  wire logic [mmsw_pkg::K_W-1:0] cfg_wr_data,
  mmsw_in_if.sink                       in_ch,
  mmsw_out_if.source                    out_ch
);
  import mmsw_pkg::*;

  logic [K_W-1:0] window_len_r;
  logic [K_W-1:0] k_eff;
  logic           div_idle;
  logic           res_vld;
  res_t           res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= K_W'(1);
    end else if (cfg_wr_en) begin
      window_len_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (window_len_r == '0) begin
      k_eff = K_W'(1);
    end else if (window_len_r > K_W'(WINDOW_MAX)) begin
      k_eff = K_W'(WINDOW_MAX);
    end else begin
      k_eff = window_len_r;
    end
  end

  mmsw_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .k        (k_eff),
    .div_idle (div_idle),
    .in_ch    (in_ch),
    .res_vld  (res_vld),
    .res      (res)
  );

  mmsw_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (res_vld),
    .res    (res),
    .idle   (div_idle),
    .out_ch (out_ch)
  );

  `MMSW_ASSERT_NEXT(a_last_holds_off, in_ch.valid && in_ch.ready && in_ch.last, !in_ch.ready, "word accepted right after a last word")
  `MMSW_ASSERT_NEXT(a_div_starts, res_vld, !div_idle, "divider missed a finished stream")
  `MMSW_ASSERT_NOW(a_empty_result, out_ch.valid && !out_ch.found, out_ch.mean_q16 == MEAN_NONE && out_ch.best_sum == '0 && out_ch.start_index == '0 && out_ch.end_index == '0, "short stream result not cleared")

endmodule

`default_nettype wire

### rtl/mmsw_window.sv
// Window store, running sum and best-window tracking.
`default_nettype none

module mmsw_window (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [mmsw_pkg::K_W-1:0] k,
  input  wire logic                  div_idle,
  mmsw_in_if.sink                    in_ch,
  output logic                       res_vld,
  output mmsw_pkg::res_t             res
);
  import mmsw_pkg::*;

  logic [VALUE_W-1:0] mem [WINDOW_MAX];
  logic [VALUE_W-1:0] rd_data_r;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             acc, upd;
  logic [CNT_W-1:0] idx_p1, k_ext;
  logic [AW-1:0]    wr_addr, rd_addr;

  logic               b_vld_r;
  logic               b_upd_r, b_last_r, b_drop_r, b_first_r, b_past_r;
  logic               b_found_r, b_ovf_r;
  logic [IDX_W-1:0]   b_start_r;
  logic [VALUE_W-1:0] b_value_r;

  logic signed [SUM_W-1:0] run_r, run_nxt, best_r, best_nxt;
  logic signed [SUM_W-1:0] add_v, sub_v, sum_new;
  logic [IDX_W-1:0]        bstart_r, bstart_nxt;
  logic                    better;

  // stage A: count, address, write and read the store
  assign in_ch.ready = div_idle && !(b_vld_r && b_last_r);
  assign acc     = in_ch.valid && in_ch.ready;
  assign upd     = count_r < CNT_W'(LEN_MAX);
  assign idx_p1  = count_r + CNT_W'(1);
  assign k_ext   = CNT_W'(k);
  assign wr_addr = count_r[AW-1:0];
  assign rd_addr = wr_addr - k[AW-1:0];

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (acc) begin
      if (in_ch.last) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end else begin
        count_nxt = upd ? idx_p1 : count_r;
        ovf_nxt   = ovf_r | ~upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && upd) begin
      mem[wr_addr] <= in_ch.value;
    end
    if (acc) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      b_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_upd_r   <= upd;
      b_last_r  <= in_ch.last;
      b_drop_r  <= count_r >= k_ext;
      b_first_r <= idx_p1 == k_ext;
      b_past_r  <= idx_p1 > k_ext;
      b_found_r <= (upd ? idx_p1 : count_r) >= k_ext;
      b_ovf_r   <= ovf_r | ~upd;
      b_start_r <= IDX_W'(idx_p1 - k_ext);
      b_value_r <= in_ch.value;
    end
  end

  // stage B: add new word, drop oldest, compare against best
  assign add_v   = {{(SUM_W-VALUE_W){b_value_r[VALUE_W-1]}}, b_value_r};
  assign sub_v   = b_drop_r ? {{(SUM_W-VALUE_W){rd_data_r[VALUE_W-1]}}, rd_data_r} : '0;
  assign sum_new = run_r + add_v - sub_v;
  assign better  = sum_new > best_r;

  always_comb begin
    run_nxt    = run_r;
    best_nxt   = best_r;
    bstart_nxt = bstart_r;
    if (b_vld_r && b_upd_r) begin
      run_nxt = sum_new;
      if (b_first_r) begin
        best_nxt   = sum_new;
        bstart_nxt = '0;
      end else if (b_past_r && better) begin
        best_nxt   = sum_new;
        bstart_nxt = b_start_r;
      end
    end
  end

  assign res_vld = b_vld_r && b_last_r;

  always_comb begin
    res.found       = b_found_r;
    res.overflow    = b_ovf_r;
    res.k           = k;
    res.best_sum    = b_found_r ? best_nxt : '0;
    res.start_index = b_found_r ? bstart_nxt : '0;
    res.end_index   = b_found_r ? bstart_nxt + IDX_W'(k) - IDX_W'(1) : '0;
  end

  // clear stream state once the last word has been folded in
  always_ff @(posedge clk) begin
    if (!rst_n || res_vld) begin
      run_r    <= '0;
      best_r   <= '0;
      bstart_r <= '0;
    end else begin
      run_r    <= run_nxt;
      best_r   <= best_nxt;
      bstart_r <= bstart_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/mmsw_div.sv
// Bit-serial mean divider and result output register.
`default_nettype none

module mmsw_div (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire mmsw_pkg::res_t res,
  output logic                idle,
  mmsw_out_if.source          out_ch
);
  import mmsw_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        st_r, st_nxt;
  res_t              hold_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [K_W-1:0]    rem_r;
  logic [DCNT_W-1:0] cnt_r;

  logic [SUM_W-1:0]  mag;
  logic [K_W:0]      rem_sh;
  logic              ge;
  logic [K_W:0]      rem_sub;
  logic [DVD_W-1:0]  q_signed;
  logic [MEAN_W-1:0] mean;
  logic              load;

  logic              out_vld_r;
  res_t              out_res_r;
  logic [MEAN_W-1:0] out_mean_r;

  assign mag     = res.best_sum[SUM_W-1] ? SUM_W'(-res.best_sum) : res.best_sum;
  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, hold_r.k};
  assign rem_sub = rem_sh - {1'b0, hold_r.k};

  assign q_signed = hold_r.best_sum[SUM_W-1] ? (~dvd_r + DVD_W'(1)) : dvd_r;
  assign mean     = hold_r.found ? q_signed[MEAN_W-1:0] : MEAN_NONE;

  assign idle = st_r == ST_IDLE;
  assign load = (st_r == ST_DONE) && (!out_vld_r || out_ch.ready);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (start) begin
          st_nxt = res.found ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (cnt_r == DCNT_W'(DVD_W - 1)) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // one quotient bit per cycle, shifted in behind the dividend
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && start) begin
      hold_r <= res;
      dvd_r  <= {mag, {FRAC{1'b0}}};
      rem_r  <= '0;
      cnt_r  <= '0;
    end else if (st_r == ST_RUN) begin
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
      rem_r <= ge ? rem_sub[K_W-1:0] : rem_sh[K_W-1:0];
      cnt_r <= cnt_r + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r  <= hold_r;
      out_mean_r <= mean;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.found       = out_res_r.found;
  assign out_ch.overflow    = out_res_r.overflow;
  assign out_ch.best_sum    = out_res_r.best_sum;
  assign out_ch.mean_q16    = out_mean_r;
  assign out_ch.start_index = out_res_r.start_index;
  assign out_ch.end_index   = out_res_r.end_index;

endmodule

`default_nettype wire
